// ===== src/scf_pkg.sv =====
package scf_pkg;

    // Plot geometry and series limits
    localparam int PLOT_ROWS      = 60;
    localparam int MAX_SERIES     = 4;
    localparam int GRID_DIVISIONS = 8;

    // Field widths
    localparam int ROW_W    = 6;
    localparam int SAMPLE_W = 16;
    localparam int COLOR_W  = 32;
    localparam int COUNT_W  = 3;
    localparam int SCALE_W  = 22;
    localparam int DIV_W    = SAMPLE_W + 1;
    localparam int STEP_W   = $clog2(SCALE_W + 1);
    localparam int BAND_W   = 4;
    localparam int CFG_IDX_W = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [COLOR_W-1:0] OPAQUE_ALPHA   = 32'hff00_0000;
    localparam logic [COLOR_W-1:0] DEFAULT_SERIES = 32'hff00_ff00;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOW  = 3'd0,
        CFG_RANGE_HIGH = 3'd1,
        CFG_BACKGROUND = 3'd2,
        CFG_GRID       = 3'd3,
        CFG_SERIES_0   = 3'd4,
        CFG_SERIES_1   = 3'd5,
        CFG_SERIES_2   = 3'd6,
        CFG_SERIES_3   = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIVIDE,
        FR_PUSH
    } front_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_ROW
    } back_state_t;

    // One column job: span of rows covered by each series
    typedef struct packed {
        logic [COUNT_W-1:0]                   count;
        logic [MAX_SERIES-1:0][SCALE_W-1:0]   span_min;
        logic [MAX_SERIES-1:0][SCALE_W-1:0]   span_max;
    } job_t;

    // Colours used by the back end
    typedef struct packed {
        logic [COLOR_W-1:0]                   background;
        logic [COLOR_W-1:0]                   grid;
        logic [MAX_SERIES-1:0][COLOR_W-1:0]   series;
    } palette_t;

    // Grid band of a plot row, exact integer floor: count the band
    // boundaries at or above the row
    function automatic logic [BAND_W-1:0] row_band(input logic [ROW_W-1:0] row);
        logic [BAND_W-1:0]       band;
        logic [ROW_W+BAND_W-1:0] scaled;
        band   = '0;
        scaled = (ROW_W+BAND_W)'(row) * (ROW_W+BAND_W)'(GRID_DIVISIONS);
        for (int j = 1; j < GRID_DIVISIONS; j++)
        begin
            if (scaled >= (ROW_W+BAND_W)'(j * PLOT_ROWS))
            begin
                band = band + BAND_W'(1);
            end
        end
        return band;
    endfunction

    // True where a row opens a new band
    function automatic logic band_start(input logic [ROW_W-1:0] row);
        logic [ROW_W-1:0] above;
        above = row - ROW_W'(1);
        return (row != '0) && (row_band(row) != row_band(above));
    endfunction

endpackage

// ===== src/strip_chart_column_render.sv =====
// Strip chart column renderer.
// Input stream (s_*): one transfer carries up to four raw samples and makes one
// new pixel column of 60 rows, top row first. Output stream (m_*): one
// transfer per pixel, m_tlast high on the bottom row of the column.
// Configuration (cfg_*): register writes by index, always ready; write only
// while the block is idle.
// Scaling: the four samples are scaled in parallel by bit-serial dividers,
// pushed as a job into the queue and popped by the back end, whose pixels
// leave through an output register. Throughput: the back end makes one
// pixel per cycle within a column when the receiver keeps up; the front end
// scales the next item meanwhile and parks it in a two-entry queue.
// When the receiver stalls, the pixel in the output register holds and the
// back end stops; the front end accepts until a job waits on a full queue.
// Reset clears the per-series history, the queue and the output register and
// loads the default ranges and colours; the block is ready at once.
module strip_chart_column_render (
    input  logic        clk,
    input  logic        rst_n,
    // series_count [2:0], sample_0 [18:3], sample_1 [34:19],
    // sample_2 [50:35], sample_3 [66:51], zero pad [71:67]
    input  logic [71:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row_index [5:0], pixel_color [37:6], zero pad [39:38]
    output logic [39:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // column_done
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [scf_pkg::SAMPLE_W-1:0] range_low_reg;
    logic [scf_pkg::SAMPLE_W-1:0] range_high_reg;
    scf_pkg::palette_t            palette_reg;
    scf_pkg::cfg_index_t          cfg_sel;

    logic [scf_pkg::MAX_SERIES-1:0][scf_pkg::SAMPLE_W-1:0] samples;
    scf_pkg::job_t                push_job;
    scf_pkg::job_t                pop_job;
    logic                         push;
    logic                         pop;
    logic                         queue_full;
    logic                         queue_empty;
    logic [scf_pkg::ROW_W-1:0]    pixel_row;
    logic [scf_pkg::COLOR_W-1:0]  pixel_color;

    assign cfg_ready = 1'b1;
    assign cfg_sel   = scf_pkg::cfg_index_t'(cfg_index);

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg          <= '0;
            range_high_reg         <= scf_pkg::SAMPLE_W'(100);
            palette_reg.background <= '0;
            palette_reg.grid       <= '0;
            for (int k = 0; k < scf_pkg::MAX_SERIES; k++)
            begin
                palette_reg.series[k] <= scf_pkg::DEFAULT_SERIES;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_sel)
                scf_pkg::CFG_RANGE_LOW:  range_low_reg  <= cfg_data[scf_pkg::SAMPLE_W-1:0];
                scf_pkg::CFG_RANGE_HIGH: range_high_reg <= cfg_data[scf_pkg::SAMPLE_W-1:0];
                scf_pkg::CFG_BACKGROUND: palette_reg.background <= cfg_data;
                scf_pkg::CFG_GRID:       palette_reg.grid       <= cfg_data;
                scf_pkg::CFG_SERIES_0:   palette_reg.series[0]  <= cfg_data;
                scf_pkg::CFG_SERIES_1:   palette_reg.series[1]  <= cfg_data;
                scf_pkg::CFG_SERIES_2:   palette_reg.series[2]  <= cfg_data;
                scf_pkg::CFG_SERIES_3:   palette_reg.series[3]  <= cfg_data;
                default:                 range_low_reg  <= range_low_reg;
            endcase
        end
    end

    // Unpack the samples
    for (genvar g = 0; g < scf_pkg::MAX_SERIES; g++)
    begin : g_sample
        assign samples[g] = s_tdata[scf_pkg::COUNT_W + g*scf_pkg::SAMPLE_W +: scf_pkg::SAMPLE_W];
    end

    scf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (s_tvalid),
        .item_ready   (s_tready),
        .item_count   (s_tdata[scf_pkg::COUNT_W-1:0]),
        .item_samples (samples),
        .range_low    (range_low_reg),
        .range_high   (range_high_reg),
        .push         (push),
        .push_job     (push_job),
        .queue_full   (queue_full)
    );

    scf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (queue_empty)
    );

    scf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_job   (pop_job),
        .pop         (pop),
        .palette     (palette_reg),
        .pixel_valid (m_tvalid),
        .pixel_ready (m_tready),
        .pixel_row   (pixel_row),
        .pixel_color (pixel_color),
        .pixel_last  (m_tlast)
    );

    assign m_tdata = {2'b00, pixel_color, pixel_row};

endmodule

// ===== src/scf_divider.sv =====
module scf_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [scf_pkg::SCALE_W-1:0] dividend,
    input  logic [scf_pkg::DIV_W-1:0]   divisor,
    output logic                        busy,
    output logic [scf_pkg::SCALE_W-1:0] quotient
);

    logic [scf_pkg::STEP_W-1:0]  steps_reg;
    logic [scf_pkg::STEP_W-1:0]  steps_next;
    logic [scf_pkg::SCALE_W-1:0] quot_reg;
    logic [scf_pkg::SCALE_W-1:0] quot_next;
    logic [scf_pkg::DIV_W-1:0]   rem_reg;
    logic [scf_pkg::DIV_W-1:0]   rem_next;
    logic [scf_pkg::DIV_W-1:0]   divisor_reg;
    logic [scf_pkg::DIV_W:0]     rem_shift;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift  = {rem_reg, quot_reg[scf_pkg::SCALE_W-1]};
        steps_next = steps_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            steps_next = scf_pkg::STEP_W'(scf_pkg::SCALE_W);
            quot_next  = dividend;
            rem_next   = '0;
        end
        else if (steps_reg != '0)
        begin
            steps_next = steps_reg - scf_pkg::STEP_W'(1);
            if (rem_shift >= {1'b0, divisor_reg})
            begin
                rem_next  = scf_pkg::DIV_W'(rem_shift - {1'b0, divisor_reg});
                quot_next = {quot_reg[scf_pkg::SCALE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[scf_pkg::DIV_W-1:0];
                quot_next = {quot_reg[scf_pkg::SCALE_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
        end
        else
        begin
            steps_reg <= steps_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    assign busy     = (steps_reg != '0);
    assign quotient = quot_reg;

endmodule

// ===== src/scf_front.sv =====
module scf_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [scf_pkg::COUNT_W-1:0]  item_count,
    input  logic [scf_pkg::MAX_SERIES-1:0][scf_pkg::SAMPLE_W-1:0] item_samples,
    input  logic [scf_pkg::SAMPLE_W-1:0] range_low,
    input  logic [scf_pkg::SAMPLE_W-1:0] range_high,
    output logic                         push,
    output scf_pkg::job_t                push_job,
    input  logic                         queue_full
);

    scf_pkg::front_state_t state_reg;
    scf_pkg::front_state_t state_next;

    logic [scf_pkg::COUNT_W-1:0]                          count_reg;
    logic [scf_pkg::COUNT_W-1:0]                          count_clamped;
    logic [scf_pkg::MAX_SERIES-1:0][scf_pkg::SCALE_W-1:0] prev_reg;
    logic [scf_pkg::MAX_SERIES-1:0][scf_pkg::SCALE_W-1:0] dividend;
    logic [scf_pkg::MAX_SERIES-1:0][scf_pkg::SCALE_W-1:0] quotient;
    logic [scf_pkg::MAX_SERIES-1:0]                       lane_busy;
    logic [scf_pkg::DIV_W-1:0]                            divisor;
    logic [scf_pkg::DIV_W-1:0]                            high_ext;
    logic [scf_pkg::DIV_W-1:0]                            low_ext;
    logic                                                 wrapped;
    logic                                                 start;

    assign count_clamped = (item_count > scf_pkg::COUNT_W'(scf_pkg::MAX_SERIES)) ?
                           scf_pkg::COUNT_W'(scf_pkg::MAX_SERIES) : item_count;

    // Scaling divisor; an inverted range uses 1, scaling to 0 unless high+1 == low
    always_comb
    begin
        high_ext = {1'b0, range_high};
        low_ext  = {1'b0, range_low};
        wrapped  = 1'b0;
        if (range_high >= range_low)
        begin
            divisor = high_ext - low_ext + scf_pkg::DIV_W'(1);
        end
        else
        begin
            divisor = scf_pkg::DIV_W'(1);
            wrapped = (high_ext + scf_pkg::DIV_W'(1) != low_ext);
        end
    end

    // Clamp each sample and scale by the row count; absent series scale to 0
    always_comb
    begin
        for (int k = 0; k < scf_pkg::MAX_SERIES; k++)
        begin
            logic [scf_pkg::SAMPLE_W-1:0] v;
            v = item_samples[k];
            if (v > range_high)
            begin
                v = range_high;
            end
            else if (v < range_low)
            begin
                v = range_low;
            end
            if (wrapped || (scf_pkg::COUNT_W'(k) >= count_clamped))
            begin
                dividend[k] = '0;
            end
            else
            begin
                dividend[k] = scf_pkg::SCALE_W'(v) * scf_pkg::SCALE_W'(scf_pkg::PLOT_ROWS);
            end
        end
    end

    assign start = item_valid && item_ready;

    for (genvar g = 0; g < scf_pkg::MAX_SERIES; g++)
    begin : g_lane
        scf_divider u_divider (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (start),
            .dividend (dividend[g]),
            .divisor  (divisor),
            .busy     (lane_busy[g]),
            .quotient (quotient[g])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scf_pkg::FR_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = scf_pkg::FR_DIVIDE;
                end
            end
            scf_pkg::FR_DIVIDE:
            begin
                if (!lane_busy[0])
                begin
                    state_next = scf_pkg::FR_PUSH;
                end
            end
            scf_pkg::FR_PUSH:
            begin
                if (!queue_full)
                begin
                    state_next = scf_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = scf_pkg::FR_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        item_ready = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            scf_pkg::FR_IDLE:   item_ready = 1'b1;
            scf_pkg::FR_DIVIDE: item_ready = 1'b0;
            scf_pkg::FR_PUSH:   push       = !queue_full;
            default:            item_ready = 1'b0;
        endcase
    end

    // Span of each series against its last value
    always_comb
    begin
        push_job.count = count_reg;
        for (int k = 0; k < scf_pkg::MAX_SERIES; k++)
        begin
            if (quotient[k] < prev_reg[k])
            begin
                push_job.span_min[k] = quotient[k];
                push_job.span_max[k] = prev_reg[k];
            end
            else
            begin
                push_job.span_min[k] = prev_reg[k];
                push_job.span_max[k] = quotient[k];
            end
        end
    end

    // Control state and per-series history; entries beyond the count clear to 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scf_pkg::FR_IDLE;
            prev_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                prev_reg <= quotient;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            count_reg <= count_clamped;
        end
    end

endmodule

// ===== src/scf_queue.sv =====
module scf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  scf_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output scf_pkg::job_t pop_job,
    output logic          empty
);

    scf_pkg::job_t                  store [scf_pkg::QUEUE_DEPTH];
    logic [scf_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [scf_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [scf_pkg::QUEUE_AW:0]     fill_reg;
    logic [scf_pkg::QUEUE_AW:0]     fill_next;

    assign full    = (fill_reg == (scf_pkg::QUEUE_AW+1)'(scf_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_job = store[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (scf_pkg::QUEUE_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (scf_pkg::QUEUE_AW+1)'(1);
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + scf_pkg::QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + scf_pkg::QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/scf_back.sv =====
module scf_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        queue_empty,
    input  scf_pkg::job_t               queue_job,
    output logic                        pop,
    input  scf_pkg::palette_t           palette,
    output logic                        pixel_valid,
    input  logic                        pixel_ready,
    output logic [scf_pkg::ROW_W-1:0]   pixel_row,
    output logic [scf_pkg::COLOR_W-1:0] pixel_color,
    output logic                        pixel_last
);

    scf_pkg::back_state_t state_reg;
    scf_pkg::back_state_t state_next;

    scf_pkg::job_t                job_reg;
    logic [scf_pkg::ROW_W-1:0]    row_reg;
    logic [1:0]                   bump_reg;
    logic [1:0]                   bump_eff;
    logic [1:0]                   bump_next;
    logic                         out_valid_reg;
    logic [scf_pkg::ROW_W-1:0]    out_row_reg;
    logic [scf_pkg::COLOR_W-1:0]  out_color_reg;
    logic                         out_last_reg;
    logic                         out_free;
    logic                         emit;
    logic                         last_row;
    logic [scf_pkg::ROW_W:0]      height;
    logic [scf_pkg::SCALE_W-1:0]  height_ext;
    logic [scf_pkg::SCALE_W-1:0]  height_up;
    logic [scf_pkg::BAND_W-1:0]   band;
    logic [scf_pkg::COLOR_W-1:0]  color;

    assign out_free = !out_valid_reg || pixel_ready;
    assign last_row = (row_reg == scf_pkg::ROW_W'(scf_pkg::PLOT_ROWS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scf_pkg::BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = scf_pkg::BK_ROW;
                end
            end
            scf_pkg::BK_ROW:
            begin
                if (out_free && last_row)
                begin
                    state_next = scf_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = scf_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        pop  = 1'b0;
        emit = 1'b0;
        unique case (state_reg)
            scf_pkg::BK_IDLE: pop  = !queue_empty;
            scf_pkg::BK_ROW:  emit = out_free;
            default:          pop  = 1'b0;
        endcase
    end

    // Colour one pixel: first covering series, else grid band, else background
    always_comb
    begin
        logic hit;
        height     = (scf_pkg::ROW_W+1)'(scf_pkg::PLOT_ROWS) - {1'b0, row_reg};
        height_ext = scf_pkg::SCALE_W'(height);
        height_up  = height_ext + scf_pkg::SCALE_W'(1);
        band       = scf_pkg::row_band(row_reg);
        bump_eff   = scf_pkg::band_start(row_reg) ? 2'd2 : bump_reg;
        bump_next  = bump_eff;
        hit        = 1'b0;
        color      = palette.background;
        for (int k = 0; k < scf_pkg::MAX_SERIES; k++)
        begin
            if (!hit && (scf_pkg::COUNT_W'(k) < job_reg.count)
                && (height_up >= job_reg.span_min[k])
                && (height_ext <= job_reg.span_max[k]))
            begin
                hit   = 1'b1;
                color = palette.series[k];
            end
        end
        if (!hit && (bump_eff != 2'd0))
        begin
            bump_next = bump_eff - 2'd1;
            if (band == scf_pkg::BAND_W'(scf_pkg::GRID_DIVISIONS / 2))
            begin
                color = palette.grid | scf_pkg::OPAQUE_ALPHA;
            end
            else
            begin
                color = palette.grid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scf_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            bump_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // Output register empties on transfer, refills on each pixel
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                row_reg  <= '0;
                bump_reg <= '0;
            end
            else if (emit)
            begin
                row_reg  <= row_reg + scf_pkg::ROW_W'(1);
                bump_reg <= bump_next;
            end
        end
    end

    // Hold the job and the pixel payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= queue_job;
        end
        if (emit)
        begin
            out_row_reg   <= row_reg;
            out_color_reg <= color;
            out_last_reg  <= last_row;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_row   = out_row_reg;
    assign pixel_color = out_color_reg;
    assign pixel_last  = out_last_reg;

endmodule
